// File: src/hexp_pkg.sv
package hexp_pkg;

  localparam logic [7:0] CHR_COMMENT = 8'h23;
  localparam logic [7:0] CHR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] NIBBLE_MASK = 8'h0f;

  localparam logic [31:0] MAX_CHARS  = 32'hffff_ffff;
  localparam logic [23:0] MAX_LINES  = 24'hff_ffff;
  localparam logic [15:0] MAX_COLUMN = 16'hffff;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Character class worked out by the front end
  typedef struct packed {
    logic       is_hex;
    logic       is_blank;
    logic       is_comment;
    logic       is_newline;
    logic [3:0] nibble;
  } chr_class_t;

  function automatic chr_class_t classify(input logic [7:0] ch);
    chr_class_t c;
    logic [7:0] f;
    logic [7:0] v;
    c = '0;
    v = '0;
    f = ch;
    if (ch >= 8'h41 && ch <= 8'h46) begin
      f = ch | CASE_BIT;
    end
    if (f >= 8'h30 && f <= 8'h39) begin
      c.is_hex = 1'b1;
      v = (f - 8'h30) & NIBBLE_MASK;
    end else if (f >= 8'h61 && f <= 8'h66) begin
      c.is_hex = 1'b1;
      v = (f - 8'h61 + 8'h0a) & NIBBLE_MASK;
    end
    c.nibble     = v[3:0];
    c.is_blank   = (ch == CHR_SPACE) || (ch >= 8'h09 && ch <= 8'h0d);
    c.is_comment = (ch == CHR_COMMENT);
    c.is_newline = (ch == CHR_NEWLINE);
    return c;
  endfunction

endpackage

// File: src/hexp_if.sv
interface hexp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface hexp_result_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        error_code;
  logic [31:0] char_total;
  logic [23:0] line_total;
  logic [15:0] column_now;

  modport source (output valid, output byte_valid, output out_byte, output error_code,
                  output char_total, output line_total, output column_now, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input error_code,
                  input char_total, input line_total, input column_now, output ready);
endinterface

// File: src/hexp_front.sv
module hexp_front (
  hexp_char_if.sink            char_chan,
  input  logic                 queue_ready,
  output logic                 push,
  output hexp_pkg::chr_class_t push_class
);
  import hexp_pkg::*;

  assign char_chan.ready = queue_ready;
  assign push            = char_chan.valid && queue_ready;
  assign push_class      = classify(char_chan.char_in);

endmodule

// File: src/hexp_queue.sv
module hexp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hexp_pkg::chr_class_t push_class,
  output logic                 ready,
  input  logic                 pop,
  output logic                 pop_valid,
  output hexp_pkg::chr_class_t pop_class
);
  import hexp_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  chr_class_t        entries [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign ready     = (count != FullCnt);
  assign pop_valid = (count != '0);
  assign pop_class = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/hexp_back.sv
module hexp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  hexp_pkg::chr_class_t q_class,
  output logic                 q_pop,
  hexp_result_if.source        result_chan
);
  import hexp_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAIR    = 2'd1;
  localparam logic [1:0] PH_COMMENT = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        error_latched, error_next;
  logic [31:0] char_counter, char_next;
  logic [23:0] line_counter, line_next;
  logic [15:0] column_counter, column_next;
  logic        byte_hit;
  logic [7:0]  byte_val;

  logic        res_valid;
  logic        res_byte_valid;
  logic [7:0]  res_byte;

  // output register is free or being emptied this cycle
  assign q_pop = q_valid && (!res_valid || result_chan.ready);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    error_next       = error_latched;
    char_next        = char_counter;
    line_next        = line_counter;
    column_next      = column_counter;
    byte_hit         = 1'b0;
    byte_val         = '0;
    if (!error_latched) begin
      if (char_counter != MAX_CHARS) begin
        char_next = char_counter + 1'b1;
      end
      if (q_class.is_newline) begin
        if (line_counter != MAX_LINES) begin
          line_next = line_counter + 1'b1;
        end
        column_next = '0;
      end else if (column_counter != MAX_COLUMN) begin
        column_next = column_counter + 1'b1;
      end
      unique case (phase)
        PH_PAIR: begin
          if (q_class.is_hex) begin
            byte_hit   = 1'b1;
            byte_val   = {high_nibble, q_class.nibble};
            phase_next = PH_IDLE;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (q_class.is_newline) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // unused code behaves as idle
          priority if (q_class.is_blank) begin
            phase_next = PH_IDLE;
          end else if (q_class.is_comment) begin
            phase_next = PH_COMMENT;
          end else if (q_class.is_hex) begin
            high_nibble_next = q_class.nibble;
            phase_next       = PH_PAIR;
          end else begin
            error_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      high_nibble    <= '0;
      error_latched  <= 1'b0;
      char_counter   <= '0;
      line_counter   <= '0;
      column_counter <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase          <= phase_next;
        high_nibble    <= high_nibble_next;
        error_latched  <= error_next;
        char_counter   <= char_next;
        line_counter   <= line_next;
        column_counter <= column_next;
        res_valid      <= 1'b1;
      end else if (result_chan.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_byte_valid <= byte_hit;
      res_byte       <= byte_val;
    end
  end

  // counters and error are only updated on a pop, so the registered state
  // equals the result held in the output register
  assign result_chan.valid      = res_valid;
  assign result_chan.byte_valid = res_byte_valid;
  assign result_chan.out_byte   = res_byte;
  assign result_chan.error_code = error_latched;
  assign result_chan.char_total = char_counter;
  assign result_chan.line_total = line_counter;
  assign result_chan.column_now = column_counter;

endmodule

// File: src/hex_text_to_byte_parser_top.sv
// Hex text to byte parser: takes one character per transaction on char_chan and gives
// exactly one result transaction per character on result_chan, carrying the assembled
// byte (when the character closed a pair of hex digits), the sticky illegal-sequence
// flag and the saturating character, line and column counts. The block sustains one
// character per clock cycle while result_chan is ready; a taken character is written to the
// queue, then popped by the back end, whose parse state update fills the output register.
// A two-entry queue between the classifier and the parser, plus the output register,
// lets the input keep flowing while a result waits; ready falls only once the queue
// is full.
module hex_text_to_byte_parser_top (
  input  logic          clk,
  input  logic          rst,
  hexp_char_if.sink     char_chan,
  hexp_result_if.source result_chan
);
  import hexp_pkg::*;

  logic       push;
  chr_class_t push_class;
  logic       queue_ready;
  logic       q_valid;
  chr_class_t q_class;
  logic       q_pop;

  hexp_front u_front (
    .char_chan   (char_chan),
    .queue_ready (queue_ready),
    .push        (push),
    .push_class  (push_class)
  );

  hexp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_class (push_class),
    .ready      (queue_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_class  (q_class)
  );

  hexp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_class     (q_class),
    .q_pop       (q_pop),
    .result_chan (result_chan)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hexp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAIR    = 2'd1,
    PH_COMMENT = 2'd2
  } parse_phase_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    ERR_BLANK_IN_PAIR,
    ERR_HASH_IN_PAIR,
    ERR_NEWLINE_IN_PAIR,
    ERR_STRAY_CHAR
  } fault_kind_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        error_code;
    logic [31:0] char_total;
    logic [23:0] line_total;
    logic [15:0] column_now;
  } parse_result_t;

  // Tracks the decoder state and holds the results it should produce, oldest first
  class byte_decode_tracker;
    parse_phase_t  phase;
    logic [3:0]    held_nib;
    logic          err_seen;
    logic [31:0]   chars;
    logic [23:0]   lines;
    logic [15:0]   column;
    parse_result_t pending[$];
    int            mismatches;

    function new();
      phase      = PH_IDLE;
      held_nib   = '0;
      err_seen   = 1'b0;
      chars      = '0;
      lines      = '0;
      column     = '0;
      mismatches = 0;
    endfunction

    function bit is_blank(input logic [7:0] ch);
      return (ch == CHR_SPACE) || (ch >= 8'h09 && ch <= 8'h0d);
    endfunction

    // letters a-f / A-F share low bits 1..6, so +9 gives 10..15
    function bit hex_digit(input logic [7:0] ch, output logic [3:0] nib);
      nib = '0;
      if (ch >= "0" && ch <= "9") begin
        nib = ch[3:0];
        return 1'b1;
      end
      if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
        nib = ch[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_char(input logic [7:0] ch);
      parse_result_t r;
      logic [3:0]    nib;
      bit            digit;
      r = '0;
      if (!err_seen) begin
        if (chars != MAX_CHARS) chars++;
        if (ch == CHR_NEWLINE) begin
          if (lines != MAX_LINES) lines++;
          column = '0;
        end else if (column != MAX_COLUMN) begin
          column++;
        end
        digit = hex_digit(ch, nib);
        case (phase)
          PH_PAIR: begin
            if (digit) begin
              r.byte_valid = 1'b1;
              r.out_byte   = {held_nib, nib};
              phase        = PH_IDLE;
            end else begin
              err_seen = 1'b1;
            end
          end
          PH_COMMENT: begin
            if (ch == CHR_NEWLINE) phase = PH_IDLE;
          end
          default: begin
            if (is_blank(ch)) begin
              phase = PH_IDLE;
            end else if (ch == CHR_COMMENT) begin
              phase = PH_COMMENT;
            end else if (digit) begin
              held_nib = nib;
              phase    = PH_PAIR;
            end else begin
              err_seen = 1'b1;
            end
          end
        endcase
      end
      r.error_code = err_seen;
      r.char_total = chars;
      r.line_total = lines;
      r.column_now = column;
      pending.push_back(r);
    endfunction

    function void check_result(input parse_result_t got);
      parse_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bv=%0d byte=%02h err=%0d chars=%0d lines=%0d col=%0d",
                   got.byte_valid, got.out_byte, got.error_code, got.char_total,
                   got.line_total, got.column_now);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: bv=%0d byte=%02h err=%0d chars=%0d lines=%0d col=%0d",
                   want.byte_valid, want.out_byte, want.error_code, want.char_total,
                   want.line_total, want.column_now);
          $display("         got: bv=%0d byte=%02h err=%0d chars=%0d lines=%0d col=%0d",
                   got.byte_valid, got.out_byte, got.error_code, got.char_total,
                   got.line_total, got.column_now);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  hexp_char_if   chr_bus ();
  hexp_result_if res_bus ();

  hex_text_to_byte_parser_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_chan   (chr_bus),
    .result_chan (res_bus)
  );

  always #5 clk = ~clk;

  byte_decode_tracker tracker;
  logic [7:0]         text_q[$];
  int unsigned        send_gap_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_left = 0;
  int unsigned        stall_cycles = 0;

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      tracker.check_result({res_bus.byte_valid, res_bus.out_byte, res_bus.error_code,
                            res_bus.char_total, res_bus.line_total, res_bus.column_now});
  end

  always @(posedge clk) begin
    if ((chr_bus.valid && chr_bus.ready) || (res_bus.valid && res_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 55; end
      default:       begin send_gap_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  task automatic send_char(input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      chr_bus.valid <= 1'b0;
      @(negedge clk);
    end
    chr_bus.valid   <= 1'b1;
    chr_bus.char_in <= ch;
    do @(posedge clk); while (!chr_bus.ready);
    tracker.take_char(ch);
  endtask

  task automatic flush_text(input int hold_at);
    for (int i = 0; i < text_q.size(); i++) begin
      if (i == hold_at) hold_left = HOLD_CYCLES;
      send_char(text_q[i]);
    end
    text_q.delete();
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk);
    chr_bus.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    logic [3:0] d;
    d = 4'($urandom_range(0, 15));
    if (d < 4'd10) return "0" + 8'(d);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_blank(input bit with_nl);
    logic [7:0] blanks[6];
    blanks = '{CHR_SPACE, 8'h09, 8'h0b, 8'h0c, 8'h0d, CHR_NEWLINE};
    return blanks[$urandom_range(0, with_nl ? 5 : 4)];
  endfunction

  task automatic push_pair();
    text_q.push_back(rand_digit());
    text_q.push_back(rand_digit());
  endtask

  // comment body may hold any byte but newline
  task automatic push_comment();
    logic [7:0] c;
    text_q.push_back(CHR_COMMENT);
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      if (c == CHR_NEWLINE) c = 8'h0b;
      text_q.push_back(c);
    end
    text_q.push_back(CHR_NEWLINE);
  endtask

  task automatic build_text(input int n, input bit with_nl);
    int target;
    int pick;
    target = text_q.size() + n;
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        push_pair();
      else if (pick < 80)
        text_q.push_back(rand_blank(with_nl));
      else if (!with_nl)
        push_pair();
      else if (pick < 88)
        text_q.push_back(CHR_NEWLINE);
      else
        push_comment();
    end
  endtask

  initial begin
    fault_kind_t kind;
    logic [7:0]  stray;
    logic [3:0]  unused_nib;

    tracker         = new();
    rst             = 1'b1;
    chr_bus.valid   = 1'b0;
    chr_bus.char_in = '0;
    set_idling(IDLE_NONE);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // digit extremes in both cases, every blank, a comment holding '#', high bytes and junk
    text_q = '{"0", "9", CHR_SPACE, "a", "F", 8'h09, "A", "f", 8'h0b, 8'h0c, 8'h0d,
               CHR_NEWLINE, CHR_COMMENT, 8'hff, CHR_COMMENT, "g", 8'h00, CHR_NEWLINE,
               "5", "c", CHR_NEWLINE};
    flush_text(-1);
    wait_drained();

    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      build_text(175, 1'b1);
      flush_text((m == IDLE_NONE || m == IDLE_RECEIVER) ? 90 : -1);
      wait_drained();
      build_text(175, 1'b1);
      flush_text(-1);
    end
    wait_drained();

    // the error is sticky, so it comes last, followed by ignored noise
    set_idling(IDLE_BOTH);
    kind = fault_kind_t'($urandom_range(0, 3));
    case (kind)
      ERR_BLANK_IN_PAIR: begin
        text_q.push_back(rand_digit());
        text_q.push_back(rand_blank(1'b0));
      end
      ERR_HASH_IN_PAIR: begin
        text_q.push_back(rand_digit());
        text_q.push_back(CHR_COMMENT);
      end
      ERR_NEWLINE_IN_PAIR: begin
        text_q.push_back(rand_digit());
        text_q.push_back(CHR_NEWLINE);
      end
      default: begin
        do stray = 8'($urandom_range(0, 255));
        while (tracker.hex_digit(stray, unused_nib) || tracker.is_blank(stray) ||
               stray == CHR_COMMENT);
        text_q.push_back(stray);
      end
    endcase
    repeat (48) text_q.push_back(8'($urandom_range(0, 255)));
    flush_text(-1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $display("%0d results never arrived", tracker.pending.size());
      tracker.mismatches += tracker.pending.size();
    end
    if (tracker.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
src/hexp_pkg.sv
src/hexp_if.sv
src/hexp_front.sv
src/hexp_queue.sv
src/hexp_back.sv
src/hex_text_to_byte_parser_top.sv
tb/tb_top.sv
